[rtl/keyed_message_deframer_descrambler_unit_defines.svh]
// assertion macros used by the checker file
`ifndef KEYED_MESSAGE_DEFRAMER_DESCRAMBLER_UNIT_DEFINES_SVH
`define KEYED_MESSAGE_DEFRAMER_DESCRAMBLER_UNIT_DEFINES_SVH

// assertion on a given clock with a synchronous active-low reset
`define KMDD_ASSERT_ON(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("kmdd assertion failed");

// assertion on the block clock and reset
`define KMDD_ASSERT(lbl, prop) `KMDD_ASSERT_ON(lbl, i_clk, i_rst_n, prop)

`endif

[rtl/kmdd_pkg.sv]
package kmdd_pkg;

    localparam logic [15:0] HDR_BYTES    = 16'd3;
    localparam logic [15:0] MAX_BODY_RST = 16'd8192;

    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_EMPTY    = 2'd1,
        KIND_OVERSIZE = 2'd2
    } t_kind;

    // per-byte result of the body lane
    typedef struct packed {
        logic [7:0]  plain;
        logic        last;
        logic [15:0] pos_next;
    } t_body_res;

endpackage

[rtl/kmdd_if.sv]
interface kmdd_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] max_body_length;

    modport source (output valid, output max_body_length, input ready);
    modport sink (input valid, input max_body_length, output ready);
endinterface

interface kmdd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface kmdd_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  plain_byte;
    logic [15:0] byte_index;
    logic [7:0]  message_key;
    logic [15:0] body_length;
    logic        last;

    modport source (
        output valid, output kind, output plain_byte, output byte_index,
        output message_key, output body_length, output last, input ready
    );
    modport sink (
        input valid, input kind, input plain_byte, input byte_index,
        input message_key, input body_length, input last, output ready
    );
endinterface

[rtl/keyed_message_deframer_descrambler_unit.sv]
// channel   dir  modport  payload
// i_cfg     in   sink     max_body_length[15:0]
// i_rx      in   sink     rx_byte[7:0]
// o_res     out  source   kind, plain_byte, byte_index, message_key, body_length, last
//
// one byte per cycle while i_rx.ready is high: each byte is parsed in the cycle it
// is taken, body bytes are descrambled there too, and any result lands in the output register on the same edge.
// a stalled result holds the output register; i_rx.ready drops only while a
// result is waiting and o_res.ready is low. i_cfg is always ready.
// reset returns to key parsing with max_body_length at 8192.
module keyed_message_deframer_descrambler_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    kmdd_cfg_if.sink   i_cfg,
    kmdd_rx_if.sink    i_rx,
    kmdd_res_if.source o_res
);
    import kmdd_pkg::*;

    typedef enum logic [1:0] {
        PH_KEY,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_BODY
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_max, n_max;
    logic [7:0]  r_key, n_key;
    logic [7:0]  r_len_low, n_len_low;
    logic [15:0] r_body_len, n_body_len;
    logic [15:0] r_body_pos, n_body_pos;

    logic        r_out_valid, n_out_valid;
    t_kind       r_kind, n_kind;
    logic [7:0]  r_plain, n_plain;
    logic [15:0] r_index, n_index;
    logic [7:0]  r_msg_key, n_msg_key;
    logic [15:0] r_out_len, n_out_len;
    logic        r_last, n_last;

    logic        in_ready;
    logic        take;
    logic [15:0] total;
    logic [15:0] hdr_len;
    t_body_res   body_res;

    kmdd_descramble u_descramble (
        .i_byte     (i_rx.rx_byte),
        .i_key      (r_key),
        .i_body_len (r_body_len),
        .i_body_pos (r_body_pos),
        .o_res      (body_res)
    );

    assign in_ready = !r_out_valid || o_res.ready;
    assign take     = i_rx.valid && in_ready;
    assign total    = {i_rx.rx_byte, r_len_low};
    assign hdr_len  = total - HDR_BYTES;

    always_comb begin
        n_phase     = r_phase;
        n_max       = r_max;
        n_key       = r_key;
        n_len_low   = r_len_low;
        n_body_len  = r_body_len;
        n_body_pos  = r_body_pos;
        n_out_valid = r_out_valid && !o_res.ready;
        n_kind      = r_kind;
        n_plain     = r_plain;
        n_index     = r_index;
        n_msg_key   = r_msg_key;
        n_out_len   = r_out_len;
        n_last      = r_last;

        if (i_cfg.valid) begin
            n_max = i_cfg.max_body_length;
        end

        if (take) begin
            unique case (r_phase)
                PH_KEY: begin
                    n_key   = i_rx.rx_byte;
                    n_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_len_low = i_rx.rx_byte;
                    n_phase   = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_body_len = hdr_len;
                    n_body_pos = 16'd0;
                    n_msg_key  = r_key;
                    n_plain    = 8'd0;
                    n_index    = 16'd0;
                    n_last     = 1'b1;
                    n_out_len  = hdr_len;
                    priority if (total == HDR_BYTES) begin
                        n_phase     = PH_KEY;
                        n_out_valid = 1'b1;
                        n_kind      = KIND_EMPTY;
                    end else if (total < HDR_BYTES || hdr_len > r_max) begin
                        // short totals wrap to a huge length and always overflow
                        n_phase     = PH_KEY;
                        n_out_valid = 1'b1;
                        n_kind      = KIND_OVERSIZE;
                    end else begin
                        n_phase = PH_BODY;
                    end
                end
                PH_BODY: begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_DATA;
                    n_plain     = body_res.plain;
                    n_index     = r_body_pos;
                    n_msg_key   = r_key;
                    n_out_len   = r_body_len;
                    n_last      = body_res.last;
                    n_body_pos  = body_res.pos_next;
                    if (body_res.last) begin
                        n_phase = PH_KEY;
                    end
                end
                default: begin
                    n_phase = PH_KEY;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_KEY;
            r_max       <= MAX_BODY_RST;
            r_key       <= 8'd0;
            r_len_low   <= 8'd0;
            r_body_len  <= 16'd0;
            r_body_pos  <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_max       <= n_max;
            r_key       <= n_key;
            r_len_low   <= n_len_low;
            r_body_len  <= n_body_len;
            r_body_pos  <= n_body_pos;
            r_out_valid <= n_out_valid;
        end
        r_kind    <= n_kind;
        r_plain   <= n_plain;
        r_index   <= n_index;
        r_msg_key <= n_msg_key;
        r_out_len <= n_out_len;
        r_last    <= n_last;
    end

    assign i_cfg.ready       = 1'b1;
    assign i_rx.ready        = in_ready;
    assign o_res.valid       = r_out_valid;
    assign o_res.kind        = r_kind;
    assign o_res.plain_byte  = r_plain;
    assign o_res.byte_index  = r_index;
    assign o_res.message_key = r_msg_key;
    assign o_res.body_length = r_out_len;
    assign o_res.last        = r_last;

endmodule

[rtl/kmdd_descramble.sv]
module kmdd_descramble (
    input  logic [7:0]          i_byte,
    input  logic [7:0]          i_key,
    input  logic [15:0]         i_body_len,
    input  logic [15:0]         i_body_pos,
    output kmdd_pkg::t_body_res o_res
);
    import kmdd_pkg::*;

    logic [7:0]  remain_lo;
    logic [7:0]  mixed;
    logic [15:0] pos_inc;

    assign remain_lo = i_body_len[7:0] - i_body_pos[7:0];
    assign mixed     = i_byte ^ i_key ^ remain_lo;
    assign pos_inc   = i_body_pos + 16'd1;

    always_comb begin
        // a zero key leaves the body in the clear
        o_res.plain    = (i_key == 8'd0) ? i_byte : (mixed - (i_body_pos[7:0] ^ i_key));
        o_res.last     = (pos_inc == i_body_len);
        o_res.pos_next = o_res.last ? 16'd0 : pos_inc;
    end

endmodule

[rtl/kmdd_checker.sv]
`include "keyed_message_deframer_descrambler_unit_defines.svh"

module kmdd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [1:0]  i_kind,
    input logic [7:0]  i_plain_byte,
    input logic [15:0] i_byte_index,
    input logic [15:0] i_body_length,
    input logic        i_last
);
    import kmdd_pkg::*;

    logic ctrl_ok;
    logic data_ok;

    assign ctrl_ok = i_last && (i_plain_byte == 8'd0) && (i_byte_index == 16'd0);
    assign data_ok = (i_byte_index < i_body_length)
                     && (i_last == ((i_byte_index + 16'd1) == i_body_length));

    // a waiting result is not dropped
    `KMDD_ASSERT(a_res_hold, i_res_valid && !i_res_ready |=> i_res_valid)

    // empty and oversize requests close the message with a cleared byte and index
    `KMDD_ASSERT(a_ctrl_fields, i_res_valid && i_kind != KIND_DATA |-> ctrl_ok)

    `KMDD_ASSERT(a_empty_len, i_res_valid && i_kind == KIND_EMPTY |-> i_body_length == 16'd0)

    // body bytes stay inside the body and flag the final one
    `KMDD_ASSERT(a_data_pos, i_res_valid && i_kind == KIND_DATA |-> data_ok)

endmodule

bind keyed_message_deframer_descrambler_unit kmdd_checker u_kmdd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_kind        (o_res.kind),
    .i_plain_byte  (o_res.plain_byte),
    .i_byte_index  (o_res.byte_index),
    .i_body_length (o_res.body_length),
    .i_last        (o_res.last)
);

[tb/keyed_message_deframer_descrambler_unit_test.sv]
module keyed_message_deframer_descrambler_unit_test;
    import kmdd_pkg::*;

    typedef enum logic [1:0] {
        ST_KEY,
        ST_LEN_LO,
        ST_LEN_HI,
        ST_BODY
    } t_parse_state;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  plain;
        logic [15:0] idx;
        logic [7:0]  key;
        logic [15:0] blen;
        logic        last;
    } t_deframe_result;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRESSURE_HOLD  = 60;
    localparam int DRAIN_CYCLES   = 3;

    class deframe_scoreboard;
        t_deframe_result expected_q[$];
        logic [15:0]     max_len;
        t_parse_state    state;
        logic [7:0]      key;
        logic [7:0]      len_lo;
        logic [15:0]     blen;
        logic [15:0]     pos;
        int              errors;

        function new();
            max_len = MAX_BODY_RST;
            state   = ST_KEY;
            key     = 8'h00;
            len_lo  = 8'h00;
            blen    = 16'h0000;
            pos     = 16'h0000;
            errors  = 0;
        endfunction

        function void set_max_len(logic [15:0] v);
            max_len = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void push_result(t_kind k, logic [7:0] p, logic [15:0] i,
                                  logic [15:0] n, logic l);
            t_deframe_result r;
            r.kind  = k;
            r.plain = p;
            r.idx   = i;
            r.key   = key;
            r.blen  = n;
            r.last  = l;
            expected_q = {expected_q, r};
        endfunction

        // advance the parser by one received byte
        function void note_byte(logic [7:0] b);
            logic [15:0] total;
            logic [7:0]  t;
            logic [7:0]  plain;
            logic        fin;
            case (state)
                ST_KEY: begin
                    key   = b;
                    state = ST_LEN_LO;
                end
                ST_LEN_LO: begin
                    len_lo = b;
                    state  = ST_LEN_HI;
                end
                ST_LEN_HI: begin
                    total = {b, len_lo};
                    blen  = total - HDR_BYTES;
                    pos   = 16'h0000;
                    if (total == HDR_BYTES) begin
                        state = ST_KEY;
                        push_result(KIND_EMPTY, 8'h00, 16'h0000, 16'h0000, 1'b1);
                    end else if (total < HDR_BYTES || blen > max_len) begin
                        // short totals wrap to a huge body and always overflow
                        state = ST_KEY;
                        push_result(KIND_OVERSIZE, 8'h00, 16'h0000, blen, 1'b1);
                    end else begin
                        state = ST_BODY;
                    end
                end
                default: begin
                    if (key == 8'h00) begin
                        plain = b;
                    end else begin
                        t     = b ^ key ^ (blen[7:0] - pos[7:0]);
                        plain = t - (pos[7:0] ^ key);
                    end
                    fin = ((pos + 16'd1) == blen);
                    push_result(KIND_DATA, plain, pos, blen, fin);
                    if (fin) begin
                        state = ST_KEY;
                        pos   = 16'h0000;
                    end else begin
                        pos = pos + 16'd1;
                    end
                end
            endcase
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        task check_result(t_deframe_result got);
            t_deframe_result want;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result kind %0d idx %0d", got.kind, got.idx));
            end else begin
                want = expected_q[0];
                expected_q.delete(0);
                if (got.kind !== want.kind)
                    report($sformatf("kind got %0d want %0d", got.kind, want.kind));
                if (got.plain !== want.plain)
                    report($sformatf("plain_byte got %h want %h (idx %0d)",
                                     got.plain, want.plain, want.idx));
                if (got.idx !== want.idx)
                    report($sformatf("byte_index got %0d want %0d", got.idx, want.idx));
                if (got.key !== want.key)
                    report($sformatf("message_key got %h want %h", got.key, want.key));
                if (got.blen !== want.blen)
                    report($sformatf("body_length got %0d want %0d", got.blen, want.blen));
                if (got.last !== want.last)
                    report($sformatf("last got %b want %b (idx %0d)",
                                     got.last, want.last, want.idx));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    kmdd_cfg_if cfg_ch();
    kmdd_rx_if  rx_ch();
    kmdd_res_if res_ch();

    keyed_message_deframer_descrambler_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_rx    (rx_ch),
        .o_res   (res_ch)
    );

    deframe_scoreboard sb;
    int  cur_max;
    int  items_sent;
    int  send_idle_pct;
    int  stall_pct;
    bit  pressure_go;
    bit  pressure_done;
    int  hold_left;
    int  quiet_cycles;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        i_clk                  = 1'b0;
        i_rst_n                = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.max_body_length = 16'h0000;
        rx_ch.valid            = 1'b0;
        rx_ch.rx_byte          = 8'h00;
        res_ch.ready           = 1'b0;
        send_idle_pct          = 0;
        stall_pct              = 0;
        pressure_go            = 1'b0;
        pressure_done          = 1'b0;
        hold_left              = 0;
        quiet_cycles           = 0;
        items_sent             = 0;
        cur_max                = MAX_BODY_RST;
        sb                     = new();
    end

    // result side: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            res_ch.ready <= 1'b0;
            hold_left--;
        end else if (pressure_go && !pressure_done) begin
            pressure_done = 1'b1;
            hold_left     = PRESSURE_HOLD - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_deframe_result got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.kind  = t_kind'(res_ch.kind);
            got.plain = res_ch.plain_byte;
            got.idx   = res_ch.byte_index;
            got.key   = res_ch.message_key;
            got.blen  = res_ch.body_length;
            got.last  = res_ch.last;
            sb.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    task send_byte(input logic [7:0] b);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            rx_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge i_clk); while (!rx_ch.ready);
        sb.note_byte(b);
        items_sent++;
    endtask

    task send_message(input logic [7:0] key, input logic [15:0] total,
                      input int body_cnt, input bit extremes);
        send_byte(key);
        send_byte(total[7:0]);
        send_byte(total[15:8]);
        for (int k = 0; k < body_cnt; k++) begin
            if (extremes)
                send_byte(k[0] ? 8'hFF : 8'h00);
            else
                send_byte(8'($urandom_range(255)));
        end
    endtask

    task send_random_message();
        int          r;
        int          len;
        int          body_cnt;
        logic [15:0] total;
        logic [7:0]  key;
        key = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255));
        r   = int'($urandom_range(99));
        if (r < 5) begin
            total    = HDR_BYTES;
            body_cnt = 0;
        end else if (r < 10) begin
            total    = 16'($urandom_range(2));
            body_cnt = 0;
        end else if (r < 18 && cur_max < 65532) begin
            // header just past the limit, or anywhere above it
            len      = $urandom_range(1) ? cur_max + 1
                                         : int'($urandom_range(65532, cur_max + 1));
            total    = 16'(len + 3);
            body_cnt = 0;
        end else begin
            len      = (r < 21) ? int'($urandom_range(400, 256))
                                : int'($urandom_range(24, 1));
            total    = 16'(len + 3);
            body_cnt = (len <= cur_max) ? len : 0;
        end
        send_message(key, total, body_cnt, 1'b0);
    endtask

    // only called with the byte stream stopped
    task write_max_len(input logic [15:0] v);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        cfg_ch.valid           <= 1'b1;
        cfg_ch.max_body_length <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        sb.set_max_len(v);
        cur_max = v;
    endtask

    task run_phase(input logic [15:0] max_len, input int sidle, input int rstall,
                   input bit pressure, input int n_items);
        int start;
        write_max_len(max_len);
        send_idle_pct = sidle;
        stall_pct     = rstall;
        pressure_go   = pressure;
        start         = items_sent;
        while (items_sent - start < n_items) send_random_message();
        rx_ch.valid <= 1'b0;
    endtask

    initial begin
        @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed requests at the reset limit of 8192
        send_message(8'h00, 16'd3, 0, 1'b0);
        send_message(8'hFF, 16'd0, 0, 1'b0);
        send_message(8'h5A, 16'd2, 0, 1'b0);
        send_message(8'h00, 16'd8196, 0, 1'b0);
        send_message(8'h00, 16'd6, 3, 1'b1);
        send_message(8'hFF, 16'd7, 4, 1'b1);
        rx_ch.valid <= 1'b0;

        run_phase(16'd0, 0, 0, 1'b0, 100);
        run_phase(16'd65532, 0, 0, 1'b0, 250);
        run_phase(16'd16, 51, 0, 1'b0, 250);
        run_phase(16'd300, 0, 51, 1'b0, 250);
        run_phase(16'($urandom_range(400, 1)), 28, 28, 1'b0, 200);
        run_phase(16'd65532, 0, 0, 1'b1, 175);

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
